// ===== hdl/bpis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpis_pkg
// Shared types, register codes and window test for the power-2 bulb step.
// ----------------------------------------------------------------------------
package bpis_pkg;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [31:0] de;
    logic        [15:0] iter;
    logic               sign;
  } item_t;

  typedef struct packed {
    logic        on;
    logic        negx;
    logic        alt;
    logic        flip;
    logic [31:0] window;
  } pass_cfg_t;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_ABS_WIN    = 3'd1,
    REG_YPASS_WIN  = 3'd2,
    REG_ZPASS_WIN  = 3'd3,
    REG_EST_SCALE  = 3'd4,
    REG_EST_OFFSET = 3'd5
  } reg_idx_e;

  localparam int unsigned MODE_ABS_ON = 0;
  localparam int unsigned MODE_ABS_X  = 1;
  localparam int unsigned MODE_ABS_Y  = 2;
  localparam int unsigned MODE_ABS_Z  = 3;
  localparam int unsigned MODE_YPASS  = 4;
  localparam int unsigned MODE_ZPASS  = 8;
  localparam int unsigned MODE_TWEAK  = 12;

  localparam logic [12:0] MODE_RESET       = 13'd16;
  localparam logic [31:0] ABS_WIN_RESET    = 32'd0;
  localparam logic [31:0] PASS_WIN_RESET   = 32'd16384000;
  localparam logic [23:0] EST_SCALE_RESET  = 24'd65536;
  localparam logic [31:0] EST_OFFSET_RESET = 32'd0;

  function automatic logic in_window(input logic [31:0] w, input logic [15:0] i);
    return (i >= w[15:0]) && (i < w[31:16]);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bpis_square_pass.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpis_square_pass
// One squaring pass about the y or the z axis, fully pipelined: squares,
// sums, a bit-per-stage pair of square roots, wide products and a
// bit-per-stage pair of dividers, then sign handling and saturation.
// ----------------------------------------------------------------------------
module bpis_square_pass
  import bpis_pkg::*;
#(
  parameter int unsigned FracBits = 24,
  parameter bit          PivotZ   = 1'b0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  pass_cfg_t cfg_i,
  input  logic      valid_i,
  input  item_t     item_i,
  output logic      valid_o,
  output item_t     item_o
);

  localparam int unsigned QuotBits  = 64 - FracBits;
  localparam int unsigned RootSteps = 32;

  typedef struct packed {
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] root;
  } root_t;

  typedef struct packed {
    item_t              orig;
    logic               active;
    logic               zero;
    logic signed [31:0] zval;
    logic               csgn;
    logic               xneg;
    logic               tneg;
    logic               dneg;
    logic        [63:0] m2;
  } ctl_t;

  typedef struct packed {
    item_t       orig;
    logic        active;
    logic        psgn;
    logic        qsgn;
    logic        csgn;
    logic [31:0] cm;
    logic [63:0] pp;
    logic [63:0] qq;
    logic [63:0] cc;
    logic [63:0] pq;
  } sqr_t;

  typedef struct packed {
    ctl_t        c;
    logic [31:0] cm;
    logic [63:0] tmag;
    logic [63:0] dmag;
    logic [63:0] a;
    logic [63:0] tot;
  } base_t;

  typedef struct packed {
    base_t b;
    root_t rr;
    root_t rs;
  } sq_t;

  typedef struct packed {
    ctl_t            c;
    logic [63:0]     ep;
    logic [63:0]     cp;
    logic [3:0][63:0] ap;
    logic [3:0][63:0] mp;
  } prod_t;

  typedef struct packed {
    ctl_t         c;
    logic [31:0]  de_new;
    logic [63:0]  cn;
    logic [127:0] an;
    logic [127:0] mn;
  } sum_t;

  typedef struct packed {
    logic                sat;
    logic [63:0]         rem;
    logic [63:0]         lo;
    logic [QuotBits-1:0] q;
  } div_t;

  typedef struct packed {
    ctl_t        c;
    logic [31:0] de_new;
    logic [63:0] cn;
    div_t        da;
    div_t        dm;
  } dch_t;

  typedef struct packed {
    item_t res;
    logic  active;
    logic  zero;
  } fin_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] r;
    r = {32'd0, a} * {32'd0, b};
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic root_t root_step(input root_t s);
    root_t       n;
    logic [35:0] remsh;
    logic [35:0] trial;
    remsh = {s.rem, s.v[63:62]};
    trial = {2'b00, s.root, 2'b01};
    n.v   = {s.v[61:0], 2'b00};
    if (remsh >= trial) begin
      n.rem  = 34'(remsh - trial);
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = remsh[33:0];
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic div_t div_step(input div_t s, input logic [63:0] d);
    div_t        n;
    logic [64:0] remsh;
    remsh = {s.rem, s.lo[63]};
    n.sat = s.sat;
    n.lo  = {s.lo[62:0], 1'b0};
    if (remsh >= {1'b0, d}) begin
      n.rem = 64'(remsh - {1'b0, d});
      n.q   = {s.q[QuotBits-2:0], 1'b1};
    end else begin
      n.rem = remsh[63:0];
      n.q   = {s.q[QuotBits-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic [127:0] sum_wide(input logic [3:0][63:0] p);
    return {64'd0, p[0]} + {32'd0, p[1], 32'd0} + {32'd0, p[2], 32'd0} + {p[3], 64'd0};
  endfunction

  // Stage 1: squares of the magnitudes and the cross product of the two in-plane magnitudes.
  logic signed [31:0] p0, q0, c0;
  logic [31:0]        pm0, qm0, cm0;
  sqr_t               s1_d, s1_q;
  logic               s1_vld_q;

  always_comb begin
    if (PivotZ) begin
      p0 = item_i.y;
      q0 = item_i.x;
      c0 = item_i.z;
    end else begin
      p0 = item_i.z;
      q0 = item_i.x;
      c0 = item_i.y;
    end
    pm0         = mag32(p0);
    qm0         = mag32(q0);
    cm0         = mag32(c0);
    s1_d.orig   = item_i;
    s1_d.active = cfg_i.on && in_window(cfg_i.window, item_i.iter);
    s1_d.psgn   = p0[31];
    s1_d.qsgn   = q0[31];
    s1_d.csgn   = c0[31];
    s1_d.cm     = cm0;
    s1_d.pp     = mul32(pm0, pm0);
    s1_d.qq     = mul32(qm0, qm0);
    s1_d.cc     = mul32(cm0, cm0);
    s1_d.pq     = mul32(pm0, qm0);
  end

  // Stage 2: radius sums and the difference terms.
  base_t       s2_d, s2_q;
  logic        s2_vld_q;
  logic [63:0] m2_s;
  logic [63:0] ccf_s;

  always_comb begin
    m2_s            = s1_q.pp + s1_q.qq;
    ccf_s           = s1_q.cc >> FracBits;
    s2_d.c.orig     = s1_q.orig;
    s2_d.c.active   = s1_q.active;
    s2_d.c.zero     = (m2_s == 64'd0);
    s2_d.c.zval     = sat32(-$signed(ccf_s));
    s2_d.c.csgn     = s1_q.csgn;
    s2_d.c.xneg     = s1_q.psgn ^ s1_q.qsgn;
    s2_d.c.m2       = m2_s;
    s2_d.cm         = s1_q.cm;
    s2_d.tot        = m2_s + s1_q.cc;
    s2_d.a          = {s1_q.pq[62:0], 1'b0};
    if (PivotZ) begin
      s2_d.c.tneg = (m2_s < s1_q.cc);
      s2_d.tmag   = s2_d.c.tneg ? (s1_q.cc - m2_s) : (m2_s - s1_q.cc);
    end else begin
      s2_d.c.tneg = (s1_q.cc < m2_s);
      s2_d.tmag   = s2_d.c.tneg ? (m2_s - s1_q.cc) : (s1_q.cc - m2_s);
    end
    s2_d.c.dneg = (s1_q.pp < s1_q.qq);
    s2_d.dmag   = s2_d.c.dneg ? (s1_q.qq - s1_q.pp) : (s1_q.pp - s1_q.qq);
  end

  // Square roots of the full radius and of the radius in the plane.
  sq_t                  sq_q [RootSteps];
  logic [RootSteps-1:0] sq_vld_q;

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    sq_t  cur;
    sq_t  nxt;
    logic vin;
    if (k == 0) begin : g_head
      always_comb begin
        cur.b       = s2_q;
        cur.rr.v    = s2_q.tot;
        cur.rr.rem  = '0;
        cur.rr.root = '0;
        cur.rs.v    = s2_q.c.m2;
        cur.rs.rem  = '0;
        cur.rs.root = '0;
      end
      assign vin = s2_vld_q;
    end else begin : g_body
      assign cur = sq_q[k-1];
      assign vin = sq_vld_q[k-1];
    end
    always_comb begin
      nxt    = cur;
      nxt.rr = root_step(cur.rr);
      nxt.rs = root_step(cur.rs);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k] <= nxt;
      end
    end
  end

  // Products: estimate growth, pivot term and the two wide numerators.
  prod_t p_d, p_q;
  logic  p_vld_q;
  sq_t   sl;

  always_comb begin
    sl      = sq_q[RootSteps-1];
    p_d.c   = sl.b.c;
    p_d.ep  = mul32(sl.b.c.orig.de, sl.rr.root);
    p_d.cp  = mul32(sl.rs.root, sl.b.cm);
    p_d.ap[0] = mul32(sl.b.a[31:0], sl.b.tmag[31:0]);
    p_d.ap[1] = mul32(sl.b.a[31:0], sl.b.tmag[63:32]);
    p_d.ap[2] = mul32(sl.b.a[63:32], sl.b.tmag[31:0]);
    p_d.ap[3] = mul32(sl.b.a[63:32], sl.b.tmag[63:32]);
    p_d.mp[0] = mul32(sl.b.dmag[31:0], sl.b.tmag[31:0]);
    p_d.mp[1] = mul32(sl.b.dmag[31:0], sl.b.tmag[63:32]);
    p_d.mp[2] = mul32(sl.b.dmag[63:32], sl.b.tmag[31:0]);
    p_d.mp[3] = mul32(sl.b.dmag[63:32], sl.b.tmag[63:32]);
  end

  sum_t        w_d, w_q;
  logic        w_vld_q;
  logic [63:0] esum;

  always_comb begin
    esum     = (p_q.ep >> (FracBits - 1)) + 64'd65536;
    w_d.c    = p_q.c;
    w_d.de_new = (esum[63:32] != 32'd0) ? 32'hffffffff : esum[31:0];
    w_d.cn   = p_q.cp >> (FracBits - 1);
    w_d.an   = sum_wide(p_q.ap);
    w_d.mn   = sum_wide(p_q.mp);
  end

  // Divider set-up: an oversized quotient saturates.
  dch_t d0_d, d0_q;
  logic d0_vld_q;

  always_comb begin
    d0_d.c      = w_q.c;
    d0_d.de_new = w_q.de_new;
    d0_d.cn     = w_q.cn;
    d0_d.da.sat = (w_q.an[127:64] >= w_q.c.m2);
    d0_d.da.rem = w_q.an[127:64];
    d0_d.da.lo  = w_q.an[63:0];
    d0_d.da.q   = '0;
    d0_d.dm.sat = (w_q.mn[127:64] >= w_q.c.m2);
    d0_d.dm.rem = w_q.mn[127:64];
    d0_d.dm.lo  = w_q.mn[63:0];
    d0_d.dm.q   = '0;
  end

  dch_t                dq_q [QuotBits];
  logic [QuotBits-1:0] dq_vld_q;

  for (genvar k = 0; k < QuotBits; k++) begin : g_div
    dch_t cur;
    dch_t nxt;
    logic vin;
    if (k == 0) begin : g_head
      assign cur = d0_q;
      assign vin = d0_vld_q;
    end else begin : g_body
      assign cur = dq_q[k-1];
      assign vin = dq_vld_q[k-1];
    end
    always_comb begin
      nxt    = cur;
      nxt.da = div_step(cur.da, cur.c.m2);
      nxt.dm = div_step(cur.dm, cur.c.m2);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dq_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        dq_vld_q[k] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[k] <= nxt;
      end
    end
  end

  // Final stage: signs, alternation, saturation and write-back.
  dch_t                dl;
  logic [QuotBits-1:0] qa, qd;
  logic signed [63:0]  qn, pn, cn;
  logic                applied, sign_n;
  fin_t                fin_d, fin_q;
  logic                fin_vld_q;

  always_comb begin
    dl      = dq_q[QuotBits-1];
    qa      = dl.da.sat ? '1 : dl.da.q;
    qd      = dl.dm.sat ? '1 : dl.dm.q;
    qn      = $signed(64'(qa));
    pn      = $signed(64'(qd));
    cn      = $signed(dl.cn);
    applied = 1'b0;
    sign_n  = dl.c.orig.sign;
    if (dl.c.xneg ^ dl.c.tneg) qn = -qn;
    if (cfg_i.negx) qn = -qn;
    if (dl.c.dneg ^ dl.c.tneg) pn = -pn;
    if (dl.c.csgn) cn = -cn;
    if (cfg_i.alt) begin
      applied = dl.c.orig.sign ^ cfg_i.flip;
      if (applied) cn = -cn;
      sign_n = ~applied;
    end
    fin_d.res    = dl.c.orig;
    fin_d.active = dl.c.active;
    fin_d.zero   = dl.c.zero;
    if (dl.c.active) begin
      fin_d.res.de = dl.de_new;
      if (dl.c.zero) begin
        if (PivotZ) begin
          fin_d.res.y = dl.c.zval;
          fin_d.res.z = '0;
        end else begin
          fin_d.res.x = dl.c.zval;
          fin_d.res.y = '0;
        end
      end else begin
        fin_d.res.x    = sat32(qn);
        fin_d.res.sign = sign_n;
        if (PivotZ) begin
          fin_d.res.y = sat32(pn);
          fin_d.res.z = sat32(cn);
        end else begin
          fin_d.res.z = sat32(pn);
          fin_d.res.y = sat32(cn);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      p_vld_q   <= 1'b0;
      w_vld_q   <= 1'b0;
      d0_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q  <= valid_i;
      s2_vld_q  <= s1_vld_q;
      p_vld_q   <= sq_vld_q[RootSteps-1];
      w_vld_q   <= p_vld_q;
      d0_vld_q  <= w_vld_q;
      fin_vld_q <= dq_vld_q[QuotBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      p_q   <= p_d;
      w_q   <= w_d;
      d0_q  <= d0_d;
      fin_q <= fin_d;
    end
  end

  assign valid_o = fin_vld_q;
  assign item_o  = fin_q.res;

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i && fin_vld_q |=> fin_vld_q && $stable(fin_q))
    else $error("pass output changed while stalled");

  a_zero_pivot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && fin_q.active && fin_q.zero |->
      (PivotZ ? (fin_q.res.z == 32'sd0) : (fin_q.res.y == 32'sd0)))
    else $error("zero radius left the pivot coordinate set");

  a_inactive_keeps_de : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && fin_q.res.de < 32'd65536 |-> !fin_q.active)
    else $error("active pass gave an estimate below one");

endmodule
`default_nettype wire

// ===== hdl/bulb_pow2_iteration_step_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bulb_pow2_iteration_step_core
// Trig-free power-2 bulb iteration for one point per request: optional
// absolute value, a y-axis and a z-axis squaring pass and an estimate tweak.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                 Content
//  s_axis    in         tvalid tready tdata     x, y, z, estimate, iteration
//                       tuser                   sign
//  m_axis    out        tvalid tready tdata     x, y, z, estimate
//                       tuser                   sign
//  cfg       in         valid ready index data  register writes, always ready
//
//  One request enters every cycle while the output is not held. Each of the
//  two passes holds bit-per-stage square roots and 64 - COORD_FRAC_BITS
//  divider stages.
//  Reset clears the valid bits and loads the register defaults.
//  When the output is held, the whole pipeline holds and nothing is lost.
// ----------------------------------------------------------------------------
module bulb_pow2_iteration_step_core
  import bpis_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // x [31:0], y [63:32], z [95:64], estimate [127:96], iteration [143:128]
  input  logic [143:0] s_axis_tdata,
  // sign [0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // x [31:0], y [63:32], z [95:64], estimate [127:96]
  output logic [127:0] m_axis_tdata,
  // sign [0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  typedef struct packed {
    item_t       it;
    logic [55:0] tp;
  } tw_t;

  logic [12:0]        mode_q;
  logic [31:0]        abs_win_q, ypass_win_q, zpass_win_q;
  logic [23:0]        est_scale_q;
  logic signed [31:0] est_offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_RESET;
      abs_win_q    <= ABS_WIN_RESET;
      ypass_win_q  <= PASS_WIN_RESET;
      zpass_win_q  <= PASS_WIN_RESET;
      est_scale_q  <= EST_SCALE_RESET;
      est_offset_q <= EST_OFFSET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:       mode_q       <= cfg_data_i[12:0];
        REG_ABS_WIN:    abs_win_q    <= cfg_data_i;
        REG_YPASS_WIN:  ypass_win_q  <= cfg_data_i;
        REG_ZPASS_WIN:  zpass_win_q  <= cfg_data_i;
        REG_EST_SCALE:  est_scale_q  <= cfg_data_i[23:0];
        REG_EST_OFFSET: est_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic signed [31:0] abs_sat(input logic signed [31:0] v);
    if (v == 32'sh80000000) return 32'sh7fffffff;
    return v[31] ? -v : v;
  endfunction

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  item_t in_d, in_q;
  logic  in_vld_q;
  logic  abs_act;

  always_comb begin
    in_d.x    = s_axis_tdata[31:0];
    in_d.y    = s_axis_tdata[63:32];
    in_d.z    = s_axis_tdata[95:64];
    in_d.de   = s_axis_tdata[127:96];
    in_d.iter = s_axis_tdata[143:128];
    in_d.sign = s_axis_tuser;
    abs_act   = mode_q[MODE_ABS_ON] && in_window(abs_win_q, in_d.iter);
    if (abs_act && mode_q[MODE_ABS_X]) in_d.x = abs_sat(in_d.x);
    if (abs_act && mode_q[MODE_ABS_Y]) in_d.y = abs_sat(in_d.y);
    if (abs_act && mode_q[MODE_ABS_Z]) in_d.z = abs_sat(in_d.z);
  end

  pass_cfg_t ycfg, zcfg;

  always_comb begin
    ycfg.on     = mode_q[MODE_YPASS];
    ycfg.negx   = mode_q[MODE_YPASS+1];
    ycfg.alt    = mode_q[MODE_YPASS+2];
    ycfg.flip   = mode_q[MODE_YPASS+3];
    ycfg.window = ypass_win_q;
    zcfg.on     = mode_q[MODE_ZPASS];
    zcfg.negx   = mode_q[MODE_ZPASS+1];
    zcfg.alt    = mode_q[MODE_ZPASS+2];
    zcfg.flip   = mode_q[MODE_ZPASS+3];
    zcfg.window = zpass_win_q;
  end

  logic  y_vld, z_vld;
  item_t y_item, z_item;

  bpis_square_pass #(
    .FracBits (COORD_FRAC_BITS),
    .PivotZ   (1'b0)
  ) u_ypass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (ycfg),
    .valid_i (in_vld_q),
    .item_i  (in_q),
    .valid_o (y_vld),
    .item_o  (y_item)
  );

  bpis_square_pass #(
    .FracBits (COORD_FRAC_BITS),
    .PivotZ   (1'b1)
  ) u_zpass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (zcfg),
    .valid_i (y_vld),
    .item_i  (y_item),
    .valid_o (z_vld),
    .item_o  (z_item)
  );

  tw_t                tw_d, tw_q;
  logic               tw_vld_q;
  item_t              out_d, out_q;
  logic signed [41:0] tv;

  always_comb begin
    tw_d.it = z_item;
    tw_d.tp = {24'd0, z_item.de} * {32'd0, est_scale_q};
  end

  always_comb begin
    out_d = tw_q.it;
    tv    = $signed({2'b00, tw_q.tp[55:16]}) + 42'(est_offset_q);
    if (mode_q[MODE_TWEAK]) begin
      if (tv < 42'sd0) begin
        out_d.de = '0;
      end else if (tv > 42'sd4294967295) begin
        out_d.de = '1;
      end else begin
        out_d.de = tv[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      tw_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= s_axis_tvalid;
      tw_vld_q  <= z_vld;
      out_vld_q <= tw_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q  <= in_d;
      tw_q  <= tw_d;
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.de, out_q.z, out_q.y, out_q.x};
  assign m_axis_tuser  = out_q.sign;

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with an empty output register");

  a_out_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while held");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("register channel not ready");

endmodule
`default_nettype wire
